@@ hw/rtl/numeric_field_sort_key_encoder_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the sort key encoder
// Each macro expects signals named clk and rst_n in the enclosing module.
// ----------------------------------------------------------------------------
`ifndef NUMERIC_FIELD_SORT_KEY_ENCODER_DEFINES_SVH
`define NUMERIC_FIELD_SORT_KEY_ENCODER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NFSKE_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nfske: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define NFSKE_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nfske: next-cycle check failed");

`endif

@@ hw/rtl/nfske_pkg.sv @@
// ----------------------------------------------------------------------------
// nfske_pkg
// Types and constants shared by the sort key encoder modules.
// ----------------------------------------------------------------------------
package nfske_pkg;

    // One input beat: a byte of a record field with its tags.
    typedef struct packed {
        logic [7:0] data_byte;
        logic [2:0] field_format;
        logic       descending;
        logic       field_end;
    } src_item_t;

    // One output beat: key bytes, right-aligned and big-endian.
    typedef struct packed {
        logic [63:0] key_data;
        logic [3:0]  key_bytes;
        logic        field_done;
    } key_item_t;

    // Field format codes.
    localparam logic [2:0] FMT_CHAR   = 3'd0;
    localparam logic [2:0] FMT_ZONED  = 3'd1;
    localparam logic [2:0] FMT_PACKED = 3'd2;
    localparam logic [2:0] FMT_UBIN   = 3'd3;
    localparam logic [2:0] FMT_SBIN   = 3'd4;
    localparam logic [2:0] FMT_DSTR   = 3'd5;

    // Accumulator operation for one byte.
    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_MUL10,
        ACC_MUL100,
        ACC_SHIFT8
    } acc_op_t;

    // How the final value becomes a signed 64-bit number.
    typedef enum logic [1:0] {
        FIN_SIGN_MAG,
        FIN_UNSIGNED,
        FIN_SIGN_EXT,
        FIN_ZERO
    } fin_mode_t;

    // Decoded step handed from the front end to the back end.
    typedef struct packed {
        logic       is_char;
        acc_op_t    acc_op;
        logic [7:0] operand;
        logic       neg_wr;
        logic       neg_val;
        logic       last;
        logic       desc;
        fin_mode_t  fin_mode;
        logic [3:0] count;
    } step_t;

    localparam logic [63:0] SIGN_FLIP      = 64'h8000_0000_0000_0000;
    localparam logic [3:0]  KEY_BYTES_CHAR = 4'd1;
    localparam logic [3:0]  KEY_BYTES_NUM  = 4'd8;
    localparam logic [3:0]  BYTES_SAT      = 4'd8;

    // Character codes used by the decimal decoders.
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_I   = 8'h49;
    localparam logic [7:0] CH_UP_J   = 8'h4A;
    localparam logic [7:0] CH_UP_R   = 8'h52;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [3:0] ZONE_ASCII_POS  = 4'h3;
    localparam logic [3:0] ZONE_ASCII_NEG  = 4'h7;
    localparam logic [3:0] ZONE_EBCDIC_POS = 4'hC;
    localparam logic [3:0] ZONE_EBCDIC_NEG = 4'hD;
    localparam logic [3:0] SIGN_NIB_NEG    = 4'hD;
    localparam logic [3:0] SIGN_NIB_ALT    = 4'hB;

endpackage

@@ hw/rtl/nfske_front.sv @@
// ----------------------------------------------------------------------------
// nfske_front
// Accepts field bytes, tracks the per-field scan state and decodes each byte
// into an accumulator step for the back end.
// ----------------------------------------------------------------------------
module nfske_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 src_valid,
    output logic                 src_ready,
    input  nfske_pkg::src_item_t src_item,
    input  logic                 queue_full,
    output logic                 push,
    output nfske_pkg::step_t     push_item
);
    import nfske_pkg::*;

    typedef enum logic [1:0] {
        PH_LEAD,
        PH_DIGITS,
        PH_STOP
    } str_phase_t;

    str_phase_t phase_reg, phase_next;
    logic [3:0] seen_reg, seen_next, seen_count;
    logic [7:0] c;
    logic [3:0] hi, lo;
    logic       lo_digit, is_digit;
    step_t      step;

    assign src_ready = !queue_full;
    assign push      = src_valid && src_ready;
    assign push_item = step;

    assign c        = src_item.data_byte;
    assign hi       = c[7:4];
    assign lo       = c[3:0];
    assign lo_digit = (lo <= 4'd9);
    assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);

    // Decode one byte into an accumulator step.
    always_comb
    begin
        step         = '0;
        step.acc_op  = ACC_HOLD;
        step.last    = src_item.field_end;
        step.desc    = src_item.descending;
        step.operand = 8'd0;
        phase_next   = phase_reg;

        if ((src_item.field_format != FMT_CHAR) && (seen_reg < BYTES_SAT))
        begin
            seen_count = seen_reg + 4'd1;
        end
        else
        begin
            seen_count = seen_reg;
        end
        step.count = seen_count;

        unique case (src_item.field_format)
            FMT_UBIN:   step.fin_mode = FIN_UNSIGNED;
            FMT_SBIN:   step.fin_mode = FIN_SIGN_EXT;
            FMT_ZONED,
            FMT_PACKED,
            FMT_DSTR:   step.fin_mode = FIN_SIGN_MAG;
            default:    step.fin_mode = FIN_ZERO;
        endcase

        unique case (src_item.field_format)
            FMT_CHAR:
            begin
                step.is_char = 1'b1;
                step.operand = c;
            end
            FMT_ZONED:
            begin
                // Plain and overpunched zoned digits, in either character set.
                priority if (lo_digit && (hi == ZONE_ASCII_POS || hi == ZONE_EBCDIC_POS))
                begin
                    step.acc_op  = ACC_MUL10;
                    step.operand = {4'h0, lo};
                end
                else if (lo_digit && (hi == ZONE_ASCII_NEG || hi == ZONE_EBCDIC_NEG))
                begin
                    step.acc_op  = ACC_MUL10;
                    step.operand = {4'h0, lo};
                    step.neg_wr  = 1'b1;
                    step.neg_val = 1'b1;
                end
                else if (c == CH_LBRACE)
                begin
                    step.acc_op = ACC_MUL10;
                end
                else if ((c >= CH_UP_A) && (c <= CH_UP_I))
                begin
                    step.acc_op  = ACC_MUL10;
                    step.operand = c - (CH_UP_A - 8'd1);
                end
                else if (c == CH_RBRACE)
                begin
                    step.acc_op  = ACC_MUL10;
                    step.neg_wr  = 1'b1;
                    step.neg_val = 1'b1;
                end
                else if ((c >= CH_UP_J) && (c <= CH_UP_R))
                begin
                    step.acc_op  = ACC_MUL10;
                    step.operand = c - (CH_UP_J - 8'd1);
                    step.neg_wr  = 1'b1;
                    step.neg_val = 1'b1;
                end
                else if (c == CH_MINUS)
                begin
                    step.neg_wr  = 1'b1;
                    step.neg_val = 1'b1;
                end
                else
                begin
                    step.acc_op = ACC_HOLD;
                end
            end
            FMT_PACKED:
            begin
                // Two digits per byte; the last low nibble carries the sign.
                if (!src_item.field_end)
                begin
                    step.acc_op  = ACC_MUL100;
                    step.operand = ({4'h0, hi} * 8'd10) + {4'h0, lo};
                end
                else
                begin
                    step.acc_op  = ACC_MUL10;
                    step.operand = {4'h0, hi};
                    step.neg_wr  = 1'b1;
                    step.neg_val = (lo == SIGN_NIB_NEG) || (lo == SIGN_NIB_ALT);
                end
            end
            FMT_UBIN,
            FMT_SBIN:
            begin
                step.acc_op  = ACC_SHIFT8;
                step.operand = c;
            end
            FMT_DSTR:
            begin
                // Leading blanks, optional sign, digits, then stop for good.
                unique case (phase_reg)
                    PH_LEAD:
                    begin
                        if (c == CH_SPACE)
                        begin
                            phase_next = PH_LEAD;
                        end
                        else if ((c == CH_MINUS) || (c == CH_PLUS))
                        begin
                            step.neg_wr  = 1'b1;
                            step.neg_val = (c == CH_MINUS);
                            phase_next   = PH_DIGITS;
                        end
                        else if (is_digit)
                        begin
                            step.acc_op  = ACC_MUL10;
                            step.operand = {4'h0, lo};
                            phase_next   = PH_DIGITS;
                        end
                        else
                        begin
                            phase_next = PH_STOP;
                        end
                    end
                    PH_DIGITS:
                    begin
                        if (is_digit)
                        begin
                            step.acc_op  = ACC_MUL10;
                            step.operand = {4'h0, lo};
                        end
                        else
                        begin
                            phase_next = PH_STOP;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_STOP;
                    end
                endcase
            end
            default:
            begin
                step.acc_op = ACC_HOLD;
            end
        endcase

        // Every field end restarts the scan state.
        if (src_item.field_end)
        begin
            phase_next = PH_LEAD;
            seen_next  = 4'd0;
        end
        else
        begin
            seen_next = seen_count;
        end
    end

    // Scan state advances only on an accepted beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_LEAD;
            seen_reg  <= 4'd0;
        end
        else if (push)
        begin
            phase_reg <= phase_next;
            seen_reg  <= seen_next;
        end
    end

endmodule

@@ hw/rtl/nfske_queue.sv @@
// ----------------------------------------------------------------------------
// nfske_queue
// Small FIFO of decoded steps between the front end and the back end.
// ----------------------------------------------------------------------------
`include "numeric_field_sort_key_encoder_defines.svh"

module nfske_queue #(
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  nfske_pkg::step_t push_item,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output nfske_pkg::step_t head_item
);
    import nfske_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(DEPTH);

    step_t            mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full       = (count_reg == CNT_FULL);
    assign head_valid = (count_reg != '0);
    assign head_item  = mem[rd_ptr_reg];

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    `NFSKE_ASSERT_IMP(a_no_overflow, push, !full)
    `NFSKE_ASSERT_IMP(a_no_underflow, pop, head_valid)
    `NFSKE_ASSERT_NXT(a_count_up, push && !pop, count_reg == $past(count_reg) + 1'b1)

endmodule

@@ hw/rtl/nfske_back.sv @@
// ----------------------------------------------------------------------------
// nfske_back
// Runs the accumulator steps, then folds sign and order into the final key
// in a second stage and holds it in the output register.
// ----------------------------------------------------------------------------
`include "numeric_field_sort_key_encoder_defines.svh"

module nfske_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 head_valid,
    input  nfske_pkg::step_t     head_item,
    output logic                 pop,
    output logic                 key_valid,
    input  logic                 key_ready,
    output nfske_pkg::key_item_t key_item
);
    import nfske_pkg::*;

    typedef struct packed {
        logic        is_char;
        logic [63:0] value;
        logic        neg;
        fin_mode_t   mode;
        logic [3:0]  count;
        logic        desc;
        logic        last;
    } fin_t;

    logic [63:0] acc_reg, acc_step;
    logic        neg_reg, neg_step;
    logic        fin_valid_reg, key_valid_reg;
    fin_t        fin_reg, fin_next;
    key_item_t   key_reg, key_next;
    logic        fin_ready, a_ready, fin_load;
    logic [63:0] v_signed, v_key, ext_mask;
    logic [5:0]  sign_idx;

    assign fin_ready = !key_valid_reg || key_ready;
    assign a_ready   = !fin_valid_reg || fin_ready;
    assign pop       = head_valid && a_ready;
    assign fin_load  = pop && (head_item.is_char || head_item.last);
    assign key_valid = key_valid_reg;
    assign key_item  = key_reg;

    // Accumulator step: times ten or hundred by shift-add, or a byte shift.
    always_comb
    begin
        unique case (head_item.acc_op)
            ACC_MUL10:
                acc_step = (acc_reg << 3) + (acc_reg << 1) + {56'd0, head_item.operand};
            ACC_MUL100:
                acc_step = (acc_reg << 6) + (acc_reg << 5) + (acc_reg << 2)
                         + {56'd0, head_item.operand};
            ACC_SHIFT8:
                acc_step = {acc_reg[55:0], head_item.operand};
            default:
                acc_step = acc_reg;
        endcase
        neg_step = head_item.neg_wr ? head_item.neg_val : neg_reg;

        fin_next.is_char = head_item.is_char;
        fin_next.value   = head_item.is_char ? {56'd0, head_item.operand} : acc_step;
        fin_next.neg     = neg_step;
        fin_next.mode    = head_item.fin_mode;
        fin_next.count   = head_item.count;
        fin_next.desc    = head_item.desc;
        fin_next.last    = head_item.last;
    end

    // Field state: character beats leave it alone except at a field end.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= 64'd0;
            neg_reg <= 1'b0;
        end
        else if (pop)
        begin
            if (head_item.last)
            begin
                acc_reg <= 64'd0;
                neg_reg <= 1'b0;
            end
            else if (!head_item.is_char)
            begin
                acc_reg <= acc_step;
                neg_reg <= neg_step;
            end
        end
    end

    // Final key: sign handling, sign-bit flip, complement when descending.
    always_comb
    begin
        sign_idx = {fin_reg.count[2:0], 3'b000} - 6'd1;
        ext_mask = ~64'd0 << {fin_reg.count[2:0], 3'b000};
        unique case (fin_reg.mode)
            FIN_SIGN_MAG:
                v_signed = fin_reg.neg ? (64'd0 - fin_reg.value) : fin_reg.value;
            FIN_UNSIGNED:
                v_signed = fin_reg.value;
            FIN_SIGN_EXT:
                if ((fin_reg.count < BYTES_SAT) && fin_reg.value[sign_idx])
                begin
                    v_signed = fin_reg.value | ext_mask;
                end
                else
                begin
                    v_signed = fin_reg.value;
                end
            default:
                v_signed = 64'd0;
        endcase
        v_key = (v_signed ^ SIGN_FLIP) ^ {64{fin_reg.desc}};

        if (fin_reg.is_char)
        begin
            key_next.key_data   = {56'd0, fin_reg.value[7:0] ^ {8{fin_reg.desc}}};
            key_next.key_bytes  = KEY_BYTES_CHAR;
            key_next.field_done = fin_reg.last;
        end
        else
        begin
            key_next.key_data   = v_key;
            key_next.key_bytes  = KEY_BYTES_NUM;
            key_next.field_done = 1'b1;
        end
    end

    // Pipeline valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_valid_reg <= 1'b0;
            key_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
            begin
                fin_valid_reg <= fin_load;
            end
            if (fin_ready)
            begin
                key_valid_reg <= fin_valid_reg;
            end
        end
    end

    // Pipeline payloads.
    always_ff @(posedge clk)
    begin
        if (fin_load)
        begin
            fin_reg <= fin_next;
        end
        if (fin_ready && fin_valid_reg)
        begin
            key_reg <= key_next;
        end
    end

    `NFSKE_ASSERT_NXT(a_fin_hold, fin_valid_reg && !fin_ready, fin_valid_reg && $stable(fin_reg))
    `NFSKE_ASSERT_NXT(a_field_clear, pop && head_item.last, acc_reg == 64'd0 && !neg_reg)
    `NFSKE_ASSERT_IMP(a_num_done, key_valid_reg && (key_reg.key_bytes == KEY_BYTES_NUM),
                      key_reg.field_done)

endmodule

@@ hw/rtl/numeric_field_sort_key_encoder.sv @@
// ----------------------------------------------------------------------------
// numeric_field_sort_key_encoder
// Turns record field bytes into order-preserving sort key bytes.
//
//   Channel | Handshake            | Payload              | Beat
//   --------+----------------------+----------------------+---------------------------
//   src     | src_valid/src_ready  | src_item (13 bits)   | one field byte with tags
//   key     | key_valid/key_ready  | key_item (69 bits)   | one char byte or 8-byte key
//
// One byte is accepted per cycle while the step queue is not full; the back
// end's accumulate stage takes one queued step per cycle while the key stage
// can accept, so the sustained rate is one byte per cycle with key_ready high.
// A key reaches the output through the step queue, the accumulate and key stages.
// The step queue (QUEUE_DEPTH beats) lets the input keep flowing while the
// output is stalled; the input stalls only when the queue is full.
// rst_n is asynchronous and clears the scan state, accumulator and valid bits.
// ----------------------------------------------------------------------------
module numeric_field_sort_key_encoder #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 src_valid,
    output logic                 src_ready,
    input  nfske_pkg::src_item_t src_item,
    output logic                 key_valid,
    input  logic                 key_ready,
    output nfske_pkg::key_item_t key_item
);
    import nfske_pkg::*;

    logic  queue_full, push, pop, head_valid;
    step_t push_item, head_item;

    // Byte decode and scan state.
    nfske_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .src_valid  (src_valid),
        .src_ready  (src_ready),
        .src_item   (src_item),
        .queue_full (queue_full),
        .push       (push),
        .push_item  (push_item)
    );

    // Decoupling queue.
    nfske_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    // Accumulate and key formation.
    nfske_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop),
        .key_valid  (key_valid),
        .key_ready  (key_ready),
        .key_item   (key_item)
    );

endmodule
